/* hw/rtl/titxt_pkg.sv */
// ----------------------------------------------------------------------------
// titxt_pkg
// Shared types, character codes and helpers for the TI-TXT record parser.
// ----------------------------------------------------------------------------
package titxt_pkg;

    localparam int LINE_BYTES  = 16;
    localparam int LD_W        = 6;
    localparam int AD_W        = 4;
    localparam int ADDR_DIGITS = 8;
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);

    localparam logic [LD_W-1:0] LINE_DIGITS_MAX = LD_W'(2 * LINE_BYTES);
    localparam logic [31:0]     JUMP_ADDR       = 32'h0000_0201;

    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_Q_LO  = 8'h71;
    localparam logic [7:0] CH_Q_UP  = 8'h51;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_CLOSE = 2'd1,
        KIND_END   = 2'd2,
        KIND_ERR   = 2'd3
    } titxt_kind_t;

    typedef enum logic [1:0] {
        LK_START,
        LK_ADDR,
        LK_ADDR_TAIL,
        LK_DATA
    } titxt_line_t;

    typedef struct packed {
        titxt_kind_t kind;
        logic [31:0] address;
        logic [7:0]  value;
        logic [31:0] count;
        logic        last;
    } titxt_res_t;

    typedef struct packed {
        logic [1:0] n;
        titxt_res_t r0;
        titxt_res_t r1;
    } titxt_push_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } titxt_hex_t;

    function automatic titxt_hex_t hex_decode(input logic [7:0] c);
        titxt_hex_t h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            h.val = 4'(c - 8'h30);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            h.val = 4'(c - 8'h57);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            h.val = 4'(c - 8'h37);
        end
        else
        begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

/* hw/rtl/titxt_ifs.sv */
// ----------------------------------------------------------------------------
// titxt_ifs
// Valid/ready channels for the character input and the result output.
// ----------------------------------------------------------------------------
interface titxt_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink   (input valid, input ch, output ready);
endinterface

interface titxt_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] address;
    logic [7:0]  value;
    logic [31:0] count;
    logic        last;

    modport source (output valid, output kind, output address, output value,
                    output count, output last, input ready);
    modport sink   (input valid, input kind, input address, input value,
                    input count, input last, output ready);
endinterface

/* hw/rtl/ti_txt_record_parser_unit.sv */
// ----------------------------------------------------------------------------
// ti_txt_record_parser_unit
// TI-TXT image decoder, one character per word.
//
// chr carries one ASCII character per word; res carries result words
// (kind, address, value, count, last). A character yields no, one or two
// result words; last marks the final word a character caused.
// The decoder state updates in the cycle a character is accepted and the
// results land in a four-word queue, so a result is registered in the
// queue before it is offered on res.
// Throughput is one character per cycle; the queue write port (two words)
// and its depth decide this: chr.ready stays high while at least two
// entries are free.
// When res stalls the queue fills and chr.ready drops; nothing is lost.
// Reset clears the line state, the open record and the queue. After an
// error or an image end the decoder keeps taking characters but gives no
// further results until reset.
// ----------------------------------------------------------------------------
module ti_txt_record_parser_unit
    import titxt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    titxt_char_if.sink  chr,
    titxt_res_if.source res
);

    titxt_push_t push;
    logic        room;
    logic        accept;
    logic        stopped;

    assign chr.ready = room;
    assign accept    = chr.valid && room;

    titxt_decode u_decode
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .ch      (chr.ch),
        .push    (push),
        .stopped (stopped)
    );

    titxt_rqueue u_rqueue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .room  (room),
        .res   (res)
    );

    a_silent_when_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        stopped |-> push.n == 2'd0)
        else $error("result produced after decoder stopped");

    a_pair_is_close_end: assert property (@(posedge clk) disable iff (!rst_n)
        push.n == 2'd2 |-> push.r0.kind == KIND_CLOSE && push.r1.kind == KIND_END)
        else $error("two-word result is not close then end");

    a_result_offered: assert property (@(posedge clk) disable iff (!rst_n)
        push.n != 2'd0 |=> res.valid)
        else $error("queued result not offered");

    a_stop_after_final: assert property (@(posedge clk) disable iff (!rst_n)
        (push.n != 2'd0 && (push.r0.kind == KIND_ERR
            || (push.n == 2'd1 && push.r0.kind == KIND_END)
            || push.n == 2'd2)) |=> stopped)
        else $error("decoder not stopped after error or image end");

endmodule

/* hw/rtl/titxt_decode.sv */
// ----------------------------------------------------------------------------
// titxt_decode
// Line state and record tracking; turns each accepted character into zero,
// one or two result words.
// ----------------------------------------------------------------------------
module titxt_decode
    import titxt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  ch,
    output titxt_push_t push,
    output logic        stopped
);

    titxt_line_t     line_kind_reg, line_kind_next;
    logic            record_open_reg, record_open_next;
    logic [31:0]     record_start_reg, record_start_next;
    logic [31:0]     record_count_reg, record_count_next;
    logic [LD_W-1:0] line_digits_reg, line_digits_next;
    logic [3:0]      high_nibble_reg, high_nibble_next;
    logic [31:0]     addr_accum_reg, addr_accum_next;
    logic [AD_W-1:0] addr_digits_reg, addr_digits_next;
    logic            stopped_reg, stopped_next;
    logic            err_hit;
    logic            is_q;
    titxt_hex_t      hv;

    assign hv      = hex_decode(ch);
    assign is_q    = (ch == CH_Q_LO) || (ch == CH_Q_UP);
    assign stopped = stopped_reg;

    // datapath and result words
    always_comb
    begin
        logic            do_data;
        logic [LD_W-1:0] d_digits;
        logic [3:0]      d_hn;
        titxt_res_t      close_res;
        titxt_res_t      end_res;

        record_open_next  = record_open_reg;
        record_start_next = record_start_reg;
        record_count_next = record_count_reg;
        line_digits_next  = line_digits_reg;
        high_nibble_next  = high_nibble_reg;
        addr_accum_next   = addr_accum_reg;
        addr_digits_next  = addr_digits_reg;
        stopped_next      = stopped_reg;
        push              = '0;
        err_hit           = 1'b0;
        do_data           = 1'b0;
        d_digits          = line_digits_reg;
        d_hn              = high_nibble_reg;

        close_res         = '0;
        close_res.kind    = KIND_CLOSE;
        close_res.address = record_start_reg;
        close_res.count   = record_count_reg;
        end_res           = '0;
        end_res.kind      = KIND_END;
        end_res.address   = JUMP_ADDR;

        if (accept && !stopped_reg)
        begin
            case (line_kind_reg) inside
                LK_START:
                begin
                    if (ch == CH_LF)
                    begin
                    end
                    else if (ch == CH_AT)
                    begin
                        if (record_open_reg)
                        begin
                            push.n  = 2'd1;
                            push.r0 = close_res;
                        end
                        record_open_next = 1'b0;
                        addr_accum_next  = '0;
                        addr_digits_next = '0;
                    end
                    else if (is_q)
                    begin
                        if (record_open_reg)
                        begin
                            push.n  = 2'd2;
                            push.r0 = close_res;
                            push.r1 = end_res;
                        end
                        else
                        begin
                            push.n  = 2'd1;
                            push.r0 = end_res;
                        end
                        record_open_next = 1'b0;
                        stopped_next     = 1'b1;
                    end
                    else if (!record_open_reg)
                    begin
                        err_hit = 1'b1;
                    end
                    else
                    begin
                        do_data          = 1'b1;
                        d_digits         = '0;
                        d_hn             = '0;
                        line_digits_next = '0;
                        high_nibble_next = '0;
                    end
                end
                LK_ADDR, LK_ADDR_TAIL:
                begin
                    if (ch == CH_LF)
                    begin
                        if (addr_digits_reg == '0)
                        begin
                            err_hit = 1'b1;
                        end
                        else
                        begin
                            record_open_next  = 1'b1;
                            record_start_next = addr_accum_reg;
                            record_count_next = '0;
                        end
                    end
                    else if (line_kind_reg == LK_ADDR && hv.ok)
                    begin
                        if (addr_digits_reg >= AD_W'(ADDR_DIGITS))
                        begin
                            err_hit = 1'b1;
                        end
                        else
                        begin
                            addr_accum_next  = {addr_accum_reg[27:0], hv.val};
                            addr_digits_next = addr_digits_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    if (ch == CH_LF)
                    begin
                        if (line_digits_reg[0])
                        begin
                            err_hit = 1'b1;
                        end
                        else if (line_digits_reg[LD_W-1:1] < (LD_W-1)'(LINE_BYTES)
                                 && record_open_reg)
                        begin
                            push.n           = 2'd1;
                            push.r0          = close_res;
                            record_open_next = 1'b0;
                        end
                    end
                    else
                    begin
                        do_data = 1'b1;
                    end
                end
            endcase

            if (do_data && ch != CH_SPACE)
            begin
                if (!hv.ok || d_digits >= LINE_DIGITS_MAX)
                begin
                    err_hit = 1'b1;
                end
                else
                begin
                    line_digits_next = d_digits + 1'b1;
                    if (!d_digits[0])
                    begin
                        high_nibble_next = hv.val;
                    end
                    else
                    begin
                        push.n            = 2'd1;
                        push.r0.kind      = KIND_DATA;
                        push.r0.address   = record_start_reg + record_count_reg;
                        push.r0.value     = {d_hn, hv.val};
                        record_count_next = record_count_reg + 32'd1;
                    end
                end
            end

            if (err_hit)
            begin
                push.n       = 2'd1;
                push.r0      = '0;
                push.r0.kind = KIND_ERR;
                stopped_next = 1'b1;
            end
        end

        push.r0.last = (push.n == 2'd1);
        push.r1.last = 1'b1;
    end

    // line state
    always_comb
    begin
        line_kind_next = line_kind_reg;
        if (accept && !stopped_reg)
        begin
            if (err_hit)
            begin
                line_kind_next = LK_START;
            end
            else
            begin
                unique case (line_kind_reg) inside
                    LK_START:
                    begin
                        if (ch == CH_AT)
                            line_kind_next = LK_ADDR;
                        else if (ch != CH_LF && !is_q)
                            line_kind_next = LK_DATA;
                    end
                    LK_ADDR, LK_ADDR_TAIL:
                    begin
                        if (ch == CH_LF)
                            line_kind_next = LK_START;
                        else if (line_kind_reg == LK_ADDR && !hv.ok
                                 && !(ch == CH_SPACE && addr_digits_reg == '0))
                            line_kind_next = LK_ADDR_TAIL;
                    end
                    LK_DATA:
                    begin
                        if (ch == CH_LF)
                            line_kind_next = LK_START;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_kind_reg    <= LK_START;
            record_open_reg  <= 1'b0;
            record_start_reg <= '0;
            record_count_reg <= '0;
            line_digits_reg  <= '0;
            high_nibble_reg  <= '0;
            addr_accum_reg   <= '0;
            addr_digits_reg  <= '0;
            stopped_reg      <= 1'b0;
        end
        else
        begin
            line_kind_reg    <= line_kind_next;
            record_open_reg  <= record_open_next;
            record_start_reg <= record_start_next;
            record_count_reg <= record_count_next;
            line_digits_reg  <= line_digits_next;
            high_nibble_reg  <= high_nibble_next;
            addr_accum_reg   <= addr_accum_next;
            addr_digits_reg  <= addr_digits_next;
            stopped_reg      <= stopped_next;
        end
    end

endmodule

/* hw/rtl/titxt_rqueue.sv */
// ----------------------------------------------------------------------------
// titxt_rqueue
// Small result queue: takes up to two words a cycle, hands out one.
// ----------------------------------------------------------------------------
module titxt_rqueue
    import titxt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  titxt_push_t push,
    output logic        room,
    titxt_res_if.source res
);

    titxt_res_t        mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic [QPTR_W-1:0] wr_ptr_p1;
    logic              pop;
    titxt_res_t        head;

    assign room      = (count_reg <= QCNT_W'(QDEPTH - 2));
    assign pop       = res.valid && res.ready;
    assign wr_ptr_p1 = wr_ptr_reg + 1'b1;
    assign head      = mem[rd_ptr_reg];

    assign res.valid   = (count_reg != '0);
    assign res.kind    = head.kind;
    assign res.address = head.address;
    assign res.value   = head.value;
    assign res.count   = head.count;
    assign res.last    = head.last;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push.n);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        count_next  = count_reg + QCNT_W'(push.n) - QCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
            mem[wr_ptr_reg] <= push.r0;
        if (push.n == 2'd2)
            mem[wr_ptr_p1] <= push.r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
